// ===== rtl/cmr_pkg.sv =====
package cmr_pkg;

  localparam int MAX_KEYFRAMES = 64;
  localparam int KF_W          = $clog2(MAX_KEYFRAMES);
  localparam int COMP_N        = 6;
  localparam int COMP_W        = $clog2(COMP_N);
  localparam int POSE_DEPTH    = COMP_N * MAX_KEYFRAMES;
  localparam int POSE_AW       = $clog2(POSE_DEPTH);
  localparam int COUNT_W       = 7;
  localparam int RATIO_W       = 18;
  localparam int COEF_W        = 36;
  localparam int PROD_W        = COEF_W + RATIO_W;
  localparam int ACC_W         = 56;
  localparam int QUOT_W        = 17;
  localparam int DIV_STEPS     = 17;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int MIN_KEYS      = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_ADD,
    S_T1,
    S_T2,
    S_TC,
    S_TN,
    S_DSTART,
    S_DIV,
    S_RATIO,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_SQ3,
    S_PRD,
    S_COEF,
    S_MUL,
    S_ACC,
    S_RND,
    S_KEY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_init;
    logic acc_add;
  } mac_ctl_t;

  // clamp a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] res;
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
      res = v[31:0];
    end else if (v[ACC_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

// ===== rtl/cmr_div.sv =====
module cmr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 num_mag,
  input  logic [31:0]                 den_mag,
  output logic                        busy,
  output logic [cmr_pkg::QUOT_W-1:0]  quot
);

  logic [32:0]                      rem;
  logic [31:0]                      den;
  logic [cmr_pkg::DIV_CNT_W-1:0]    cnt;
  logic [32:0]                      diff;
  logic                             ge;

  // restoring division, one quotient bit a cycle
  assign ge   = rem >= {1'b0, den};
  assign diff = rem - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= cmr_pkg::DIV_CNT_W'(cmr_pkg::DIV_STEPS);
      rem  <= {1'b0, num_mag};
      den  <= den_mag;
      quot <= '0;
    end else if (busy) begin
      quot <= {quot[cmr_pkg::QUOT_W-2:0], ge};
      rem  <= ge ? {diff[31:0], 1'b0} : {rem[31:0], 1'b0};
      cnt  <= cnt - 1'b1;
      if (cnt == cmr_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/cmr_mac.sv =====
module cmr_mac (
  input  logic                                clk,
  input  cmr_pkg::mac_ctl_t                   ctl,
  input  logic signed [cmr_pkg::COEF_W-1:0]   op_a,
  input  logic signed [cmr_pkg::RATIO_W-1:0]  op_b,
  input  logic signed [cmr_pkg::ACC_W-1:0]    acc_seed,
  output logic signed [cmr_pkg::PROD_W-1:0]   prod,
  output logic signed [cmr_pkg::ACC_W-1:0]    acc
);

  // one registered multiplier feeding one accumulator
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= op_a * op_b;
    end
    if (ctl.acc_init) begin
      acc <= acc_seed;
    end else if (ctl.acc_add) begin
      acc <= acc + cmr_pkg::ACC_W'(prod);
    end
  end

endmodule

// ===== rtl/catmull_rom_path_player.sv =====
// channel   direction  handshake             contents
// in        input      in_valid / in_stall   op, key_slot, key_time, key pose, time_delta
// out       output     out_valid / out_stall finished, pose, key_index, key_changed, time_to_next
// cfg       input      cfg_valid / cfg_ready keyframe_count write data
//
// a load request writes its six pose words one after another through the single write port
// a tick request does 4 key time reads and 17 divider steps, then works through each
// pose component in turn on the one multiplier and one pose memory port
// a tick that runs off the end of the path skips the spline and key stages
// rst is synchronous; it clears the play state, the key memories stay undefined
// in_stall is high while a request is in work; a waiting result holds the block
// only when the next result is ready to be written
module catmull_rom_path_player (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [5:0]         key_slot,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] key_pos_x,
  input  logic signed [31:0] key_pos_y,
  input  logic signed [31:0] key_pos_z,
  input  logic signed [31:0] key_at_x,
  input  logic signed [31:0] key_at_y,
  input  logic signed [31:0] key_at_z,
  input  logic [31:0]        time_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               finished,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] at_x,
  output logic signed [31:0] at_y,
  output logic signed [31:0] at_z,
  output logic signed [6:0]  key_index,
  output logic               key_changed,
  output logic signed [31:0] time_to_next,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam int KF_W    = cmr_pkg::KF_W;
  localparam int COMP_N  = cmr_pkg::COMP_N;
  localparam int COMP_W  = cmr_pkg::COMP_W;
  localparam int RATIO_W = cmr_pkg::RATIO_W;
  localparam int COEF_W  = cmr_pkg::COEF_W;
  localparam int PROD_W  = cmr_pkg::PROD_W;
  localparam int ACC_W   = cmr_pkg::ACC_W;
  localparam int CNT_W   = 3;

  cmr_pkg::state_t state, state_next;

  // configuration
  logic [cmr_pkg::COUNT_W-1:0] keyframe_count;
  logic [cmr_pkg::COUNT_W-1:0] n_eff;

  // play state
  logic [31:0]       play_time;
  logic [KF_W-1:0]   seg;
  logic signed [6:0] cur_key;
  logic signed [6:0] reported_key;

  // latched request
  logic              op_q;
  logic [KF_W-1:0]   slot_q;
  logic [31:0]       key_time_q;
  logic [31:0]       delta_q;
  logic [31:0]       pose_q [COMP_N];

  // sequencer registers
  logic [CNT_W-1:0]  cnt;
  logic [COMP_W-1:0] comp;
  logic [31:0]       t1, t2, tc, tn;
  logic              num_neg, den_neg, num_zero, ratio_sat;
  logic signed [RATIO_W-1:0] r, r2, r3;
  logic [31:0]       p [4];
  logic signed [COEF_W-1:0] ca, cb, cc, cd;
  logic [31:0]       res [COMP_N];
  logic              fin_q;
  logic signed [6:0] ki_q;
  logic              kc_q;
  logic [31:0]       ttn_q;

  // memories
  logic [31:0] tmem [cmr_pkg::MAX_KEYFRAMES];
  logic [31:0] pmem [cmr_pkg::POSE_DEPTH];
  logic [31:0] tmem_q, pmem_q;
  logic [KF_W-1:0] tmem_raddr;
  logic [cmr_pkg::POSE_AW-1:0] pmem_addr;
  logic tmem_we, pmem_we;

  // shared units
  cmr_pkg::mac_ctl_t mac_ctl;
  logic signed [COEF_W-1:0]  op_a;
  logic signed [RATIO_W-1:0] op_b;
  logic signed [ACC_W-1:0]   acc_seed;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic div_start, div_busy;
  logic [cmr_pkg::QUOT_W-1:0] quot;

  logic in_take;
  logic out_free;

  // ratio stage signals
  logic [32:0] num_w, den_w;
  logic [31:0] num_mag, den_mag;
  logic [cmr_pkg::QUOT_W-1:0] mag;
  logic signed [RATIO_W-1:0] r_calc;
  logic adv;
  logic [cmr_pkg::COUNT_W-1:0] seg_next;
  logic rewind;

  // key stage signals
  logic signed [6:0] ck_next;
  logic ck_adv;
  logic [31:0] t_next;
  logic signed [ACC_W-1:0] ttn_wide;

  // spline helpers
  logic signed [COEF_W-1:0] ps0, ps1, ps2, ps3;
  logic signed [PROD_W-1:0] r2_sum, r3_sum;
  logic signed [ACC_W-1:0]  acc_rnd;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // count clamped to the table
  always_comb begin
    if (keyframe_count < cmr_pkg::COUNT_W'(cmr_pkg::MIN_KEYS)) begin
      n_eff = cmr_pkg::COUNT_W'(cmr_pkg::MIN_KEYS);
    end else if (keyframe_count > cmr_pkg::COUNT_W'(cmr_pkg::MAX_KEYFRAMES)) begin
      n_eff = cmr_pkg::COUNT_W'(cmr_pkg::MAX_KEYFRAMES);
    end else begin
      n_eff = keyframe_count;
    end
  end

  // segment ratio: sign and magnitude around the divider
  assign num_w   = {1'b0, play_time} - {1'b0, t1};
  assign den_w   = {1'b0, t2} - {1'b0, t1};
  assign num_mag = num_w[32] ? 32'(-num_w) : num_w[31:0];
  assign den_mag = den_w[32] ? 32'(-den_w) : den_w[31:0];

  always_comb begin
    if (num_zero) begin
      mag = '0;
    end else if (ratio_sat || quot > cmr_pkg::QUOT_W'(65536)) begin
      mag = cmr_pkg::QUOT_W'(65536);
    end else begin
      mag = quot;
    end
    r_calc   = (num_neg ^ den_neg) ? -RATIO_W'(mag) : RATIO_W'(mag);
    adv      = play_time > t2;
    seg_next = cmr_pkg::COUNT_W'(seg) + cmr_pkg::COUNT_W'(adv);
    rewind   = seg_next > (n_eff - cmr_pkg::COUNT_W'(cmr_pkg::MIN_KEYS));
  end

  // current key bookkeeping
  always_comb begin
    ck_adv  = (cur_key < $signed(n_eff - 7'd2)) && (play_time > tc);
    ck_next = ck_adv ? cur_key + 7'sd1 : cur_key;
    t_next  = ck_adv ? tn : tc;
    ttn_wide = ACC_W'($signed({1'b0, t_next}) - $signed({1'b0, play_time}));
  end

  // spline coefficients and rounding
  assign ps0 = COEF_W'($signed(p[0]));
  assign ps1 = COEF_W'($signed(p[1]));
  assign ps2 = COEF_W'($signed(p[2]));
  assign ps3 = COEF_W'($signed(p[3]));
  assign r2_sum = prod + PROD_W'(32768);
  assign r3_sum = prod + (prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
  assign acc_rnd = (acc + (acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(65536))) >>> 17;
  assign acc_seed = ACC_W'(ca) <<< 16;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cmr_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = (op == cmr_pkg::OP_LOAD) ? cmr_pkg::S_LOAD : cmr_pkg::S_ADD;
        end
      end
      cmr_pkg::S_LOAD: begin
        if (cnt == CNT_W'(COMP_N - 1)) state_next = cmr_pkg::S_IDLE;
      end
      cmr_pkg::S_ADD:    state_next = cmr_pkg::S_T1;
      cmr_pkg::S_T1:     state_next = cmr_pkg::S_T2;
      cmr_pkg::S_T2:     state_next = cmr_pkg::S_TC;
      cmr_pkg::S_TC:     state_next = cmr_pkg::S_TN;
      cmr_pkg::S_TN:     state_next = cmr_pkg::S_DSTART;
      cmr_pkg::S_DSTART: state_next = cmr_pkg::S_DIV;
      cmr_pkg::S_DIV: begin
        if (!div_busy) state_next = cmr_pkg::S_RATIO;
      end
      cmr_pkg::S_RATIO:  state_next = rewind ? cmr_pkg::S_OUT : cmr_pkg::S_SQ0;
      cmr_pkg::S_SQ0:    state_next = cmr_pkg::S_SQ1;
      cmr_pkg::S_SQ1:    state_next = cmr_pkg::S_SQ2;
      cmr_pkg::S_SQ2:    state_next = cmr_pkg::S_SQ3;
      cmr_pkg::S_SQ3:    state_next = cmr_pkg::S_PRD;
      cmr_pkg::S_PRD: begin
        if (cnt == CNT_W'(4)) state_next = cmr_pkg::S_COEF;
      end
      cmr_pkg::S_COEF:   state_next = cmr_pkg::S_MUL;
      cmr_pkg::S_MUL: begin
        if (cnt == CNT_W'(2)) state_next = cmr_pkg::S_ACC;
      end
      cmr_pkg::S_ACC:    state_next = cmr_pkg::S_RND;
      cmr_pkg::S_RND: begin
        state_next = (comp == COMP_W'(COMP_N - 1)) ? cmr_pkg::S_KEY : cmr_pkg::S_PRD;
      end
      cmr_pkg::S_KEY:    state_next = cmr_pkg::S_OUT;
      cmr_pkg::S_OUT: begin
        if (out_free) state_next = cmr_pkg::S_IDLE;
      end
      default:           state_next = cmr_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    mac_ctl    = '0;
    op_a       = cb;
    op_b       = r;
    tmem_raddr = seg + KF_W'(1);
    tmem_we    = 1'b0;
    pmem_we    = 1'b0;
    pmem_addr  = {comp, seg + KF_W'(cnt[1:0])};
    div_start  = 1'b0;
    case (state)
      cmr_pkg::S_IDLE: in_stall = 1'b0;
      cmr_pkg::S_LOAD: begin
        pmem_we   = 1'b1;
        pmem_addr = {cnt, slot_q};
        tmem_we   = (cnt == '0);
      end
      cmr_pkg::S_ADD: tmem_raddr = seg + KF_W'(1);
      cmr_pkg::S_T1:  tmem_raddr = seg + KF_W'(2);
      cmr_pkg::S_T2:  tmem_raddr = KF_W'(cur_key + 7'sd1);
      cmr_pkg::S_TC:  tmem_raddr = KF_W'(cur_key + 7'sd2);
      cmr_pkg::S_DSTART: div_start = 1'b1;
      cmr_pkg::S_SQ0: begin
        mac_ctl.mul_en = 1'b1;
        op_a = COEF_W'(r);
        op_b = r;
      end
      cmr_pkg::S_SQ2: begin
        mac_ctl.mul_en = 1'b1;
        op_a = COEF_W'(r2);
        op_b = r;
      end
      cmr_pkg::S_MUL: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_init = (cnt == '0);
        mac_ctl.acc_add  = (cnt != '0);
        case (cnt)
          CNT_W'(1): begin
            op_a = cc;
            op_b = r2;
          end
          CNT_W'(2): begin
            op_a = cd;
            op_b = r3;
          end
          default: begin
            op_a = cb;
            op_b = r;
          end
        endcase
      end
      cmr_pkg::S_ACC: mac_ctl.acc_add = 1'b1;
      default: ;
    endcase
  end

  // key time memory, one registered read port
  always_ff @(posedge clk) begin
    if (tmem_we) tmem[slot_q] <= key_time_q;
    tmem_q <= tmem[tmem_raddr];
  end

  // pose memory: component in the upper address bits
  always_ff @(posedge clk) begin
    if (pmem_we) pmem[pmem_addr] <= pose_q[cnt];
    pmem_q <= pmem[pmem_addr];
  end

  cmr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_mag (num_mag),
    .den_mag (den_mag),
    .busy    (div_busy),
    .quot    (quot)
  );

  cmr_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .op_a     (op_a),
    .op_b     (op_b),
    .acc_seed (acc_seed),
    .prod     (prod),
    .acc      (acc)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keyframe_count <= cmr_pkg::COUNT_W'(cmr_pkg::MIN_KEYS);
    end else if (cfg_valid && cfg_ready) begin
      keyframe_count <= cfg_data;
    end
  end

  // request latch and datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q       <= op;
      slot_q     <= key_slot;
      key_time_q <= key_time;
      delta_q    <= time_delta;
      pose_q[0]  <= key_pos_x;
      pose_q[1]  <= key_pos_y;
      pose_q[2]  <= key_pos_z;
      pose_q[3]  <= key_at_x;
      pose_q[4]  <= key_at_y;
      pose_q[5]  <= key_at_z;
    end
    case (state)
      cmr_pkg::S_T1: t1 <= tmem_q;
      cmr_pkg::S_T2: t2 <= tmem_q;
      cmr_pkg::S_TC: tc <= tmem_q;
      cmr_pkg::S_TN: tn <= tmem_q;
      cmr_pkg::S_DSTART: begin
        num_neg   <= num_w[32];
        den_neg   <= den_w[32];
        num_zero  <= (num_w == '0);
        ratio_sat <= {1'b0, num_mag} >= {den_mag, 1'b0};
      end
      cmr_pkg::S_RATIO: begin
        r     <= adv ? '0 : r_calc;
        fin_q <= rewind;
      end
      cmr_pkg::S_SQ1: r2 <= r2_sum[16 +: RATIO_W];
      cmr_pkg::S_SQ3: r3 <= r3_sum[16 +: RATIO_W];
      cmr_pkg::S_PRD: begin
        if (cnt != '0) p[cnt[1:0] - 2'd1] <= pmem_q;
      end
      cmr_pkg::S_COEF: begin
        ca <= ps1 <<< 1;
        cb <= ps2 - ps0;
        cc <= (ps0 <<< 1) - ((ps1 <<< 2) + ps1) + (ps2 <<< 2) - ps3;
        cd <= ps1 + (ps1 <<< 1) - ps2 - (ps2 <<< 1) + ps3 - ps0;
      end
      cmr_pkg::S_RND: res[comp] <= cmr_pkg::sat32(acc_rnd);
      cmr_pkg::S_KEY: begin
        ki_q <= ck_next;
        kc_q <= ck_next != reported_key;
        if (ck_next == -7'sd1 || ck_next >= $signed(n_eff - 7'd2)) begin
          ttn_q <= 32'hFFFF_0000;
        end else begin
          ttn_q <= cmr_pkg::sat32(ttn_wide);
        end
      end
      default: ;
    endcase
  end

  // counters and play state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      comp         <= '0;
      play_time    <= '0;
      seg          <= '0;
      cur_key      <= -7'sd1;
      reported_key <= -7'sd1;
    end else begin
      case (state)
        cmr_pkg::S_IDLE: cnt <= '0;
        cmr_pkg::S_LOAD: cnt <= cnt + 1'b1;
        cmr_pkg::S_ADD: begin
          // play time saturates at the top of the range
          play_time <= ({1'b0, play_time} + {1'b0, delta_q} > 33'h0_FFFF_FFFF) ?
                       32'hFFFF_FFFF : play_time + delta_q;
        end
        cmr_pkg::S_RATIO: begin
          if (rewind) begin
            play_time <= '0;
            seg       <= '0;
            cur_key   <= 7'sd1;
          end else begin
            seg <= seg_next[KF_W-1:0];
          end
        end
        cmr_pkg::S_SQ3: begin
          cnt  <= '0;
          comp <= '0;
        end
        cmr_pkg::S_PRD: cnt <= (cnt == CNT_W'(4)) ? '0 : cnt + 1'b1;
        cmr_pkg::S_MUL: cnt <= cnt + 1'b1;
        cmr_pkg::S_RND: begin
          cnt  <= '0;
          comp <= comp + 1'b1;
        end
        cmr_pkg::S_KEY: begin
          cur_key      <= ck_next;
          reported_key <= ck_next;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cmr_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cmr_pkg::S_OUT && out_free) begin
      finished     <= fin_q;
      pos_x        <= fin_q ? '0 : res[0];
      pos_y        <= fin_q ? '0 : res[1];
      pos_z        <= fin_q ? '0 : res[2];
      at_x         <= fin_q ? '0 : res[3];
      at_y         <= fin_q ? '0 : res[4];
      at_z         <= fin_q ? '0 : res[5];
      key_index    <= fin_q ? '0 : ki_q;
      key_changed  <= fin_q ? 1'b0 : kc_q;
      time_to_next <= fin_q ? '0 : ttn_q;
    end
  end

  // a finished result carries an all-zero pose
  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> pos_x == 0 && at_z == 0 && key_index == 0 &&
                              !key_changed && time_to_next == 0)
    else $error("finished result with non-zero fields");

  // segment never left beyond the last usable one
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    seg <= KF_W'(cmr_pkg::MAX_KEYFRAMES - cmr_pkg::MIN_KEYS))
    else $error("segment index out of range");

  // a new result only comes from the output state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == cmr_pkg::S_OUT)
    else $error("result raised outside the output state");

  // the ratio is taken only once the divider is done
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == cmr_pkg::S_RATIO |-> !div_busy)
    else $error("ratio used while divider busy");

endmodule

// ===== tb/sv/path_player_checker.sv =====
`timescale 1ns / 1ps

module path_player_checker
  import cmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               op,
  input  logic [5:0]         key_slot,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] key_pos_x,
  input  logic signed [31:0] key_pos_y,
  input  logic signed [31:0] key_pos_z,
  input  logic signed [31:0] key_at_x,
  input  logic signed [31:0] key_at_y,
  input  logic signed [31:0] key_at_z,
  input  logic [31:0]        time_delta,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               finished,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] at_x,
  input  logic signed [31:0] at_y,
  input  logic signed [31:0] at_z,
  input  logic signed [6:0]  key_index,
  input  logic               key_changed,
  input  logic signed [31:0] time_to_next,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic        fin;
    logic [31:0] pos [3];
    logic [31:0] at [3];
    logic [6:0]  kidx;
    logic        kchg;
    logic [31:0] ttn;
  } pose_t;

  // predictor copy of the player
  logic [31:0] kt [MAX_KEYFRAMES];
  logic [31:0] kp [3*MAX_KEYFRAMES];
  logic [31:0] ka [3*MAX_KEYFRAMES];
  logic [31:0] ptime;
  longint      seg;
  longint      cur_key;
  longint      rep_key;
  logic [6:0]  kcount;
  pose_t       pose_due [$];

  assign pending = pose_due.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint rnd_half(input longint v, input int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] interp(input bit tgt, input longint s, input int c,
                                         input longint r);
    longint p [4];
    longint a, b, cc, d, r2, r3, sum;
    logic [5:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx = 6'(s + k);
      p[k] = tgt ? longint'($signed(ka[idx*3+c])) : longint'($signed(kp[idx*3+c]));
    end
    a  = 2 * p[1];
    b  = p[2] - p[0];
    cc = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
    d  = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
    r2 = rnd_half(r * r, 16);
    r3 = rnd_half(r2 * r, 16);
    sum = a * 65536 + b * r + cc * r2 + d * r3;
    return 32'(clamp32(rnd_half(sum, 17)));
  endfunction

  function automatic pose_t advance_play(input logic [31:0] delta);
    pose_t  res;
    longint n, pt, t1, t2, num, den, r, tn;
    n = kcount < MIN_KEYS ? MIN_KEYS : (kcount > MAX_KEYFRAMES ? MAX_KEYFRAMES : kcount);
    pt = longint'(ptime) + longint'(delta);
    if (pt > 64'hFFFF_FFFF) pt = 64'hFFFF_FFFF;
    ptime = 32'(pt);
    t1 = kt[6'(seg + 1)];
    t2 = kt[6'(seg + 2)];
    num = pt - t1;
    den = t2 - t1;
    if (den == 0) r = num > 0 ? 65536 : (num < 0 ? -65536 : 0);
    else begin
      r = (num * 65536) / den;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
    end
    if (pt > t2) begin
      seg++;
      r = 0;
    end
    res.fin = 1'b0;
    res.kidx = '0;
    res.kchg = 1'b0;
    res.ttn = '0;
    for (int c = 0; c < 3; c++) begin
      res.pos[c] = '0;
      res.at[c] = '0;
    end
    // end of path: rewind
    if (seg > n - 4) begin
      ptime = '0;
      seg = 0;
      cur_key = 1;
      res.fin = 1'b1;
      return res;
    end
    for (int c = 0; c < 3; c++) begin
      res.pos[c] = interp(1'b0, seg, c, r);
      res.at[c] = interp(1'b1, seg, c, r);
    end
    if (cur_key < n - 2 && pt > longint'(kt[6'(cur_key + 1)])) cur_key++;
    res.kidx = 7'(cur_key);
    if (cur_key != rep_key) begin
      rep_key = cur_key;
      res.kchg = 1'b1;
    end
    if (cur_key == -1 || cur_key >= n - 2) res.ttn = 32'hFFFF_0000;
    else begin
      tn = longint'(kt[6'(cur_key + 1)]) - pt;
      res.ttn = 32'(clamp32(tn));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ptime <= '0;
      seg = 0;
      cur_key = -1;
      rep_key = -1;
      kcount <= 7'd4;
      pose_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) kcount = cfg_data;
      if (in_valid && !in_stall) begin
        if (op == OP_LOAD) begin
          kt[key_slot] = key_time;
          kp[key_slot*3]   = key_pos_x;
          kp[key_slot*3+1] = key_pos_y;
          kp[key_slot*3+2] = key_pos_z;
          ka[key_slot*3]   = key_at_x;
          ka[key_slot*3+1] = key_at_y;
          ka[key_slot*3+2] = key_at_z;
        end else begin
          pose_due.push_back(advance_play(time_delta));
        end
      end
      if (out_valid && !out_stall) begin
        if (pose_due.size() == 0) begin
          report("unexpected result", 32'(finished), 32'd0);
        end else begin
          pose_t w;
          w = pose_due.pop_front();
          if (finished !== w.fin) report("finished", 32'(finished), 32'(w.fin));
          if (pos_x !== w.pos[0]) report("pos_x", pos_x, w.pos[0]);
          if (pos_y !== w.pos[1]) report("pos_y", pos_y, w.pos[1]);
          if (pos_z !== w.pos[2]) report("pos_z", pos_z, w.pos[2]);
          if (at_x !== w.at[0]) report("at_x", at_x, w.at[0]);
          if (at_y !== w.at[1]) report("at_y", at_y, w.at[1]);
          if (at_z !== w.at[2]) report("at_z", at_z, w.at[2]);
          if (key_index !== w.kidx) report("key_index", 32'(key_index), 32'(w.kidx));
          if (key_changed !== w.kchg) report("key_changed", 32'(key_changed), 32'(w.kchg));
          if (time_to_next !== w.ttn) report("time_to_next", time_to_next, w.ttn);
        end
      end
    end
  end

  initial errors = 0;

endmodule

// ===== tb/sv/tb_catmull_rom_path_player.sv =====
`timescale 1ns / 1ps

module tb_catmull_rom_path_player;
  import cmr_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE      = 150;   // longer than one tick request in work
  localparam int LONG_HOLD   = 3000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               op;
  logic [5:0]         key_slot;
  logic [31:0]        key_time;
  logic signed [31:0] key_pos_x, key_pos_y, key_pos_z;
  logic signed [31:0] key_at_x, key_at_y, key_at_z;
  logic [31:0]        time_delta;
  logic               out_valid;
  logic               out_stall;
  logic               finished;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] at_x, at_y, at_z;
  logic signed [6:0]  key_index;
  logic               key_changed;
  logic signed [31:0] time_to_next;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;

  int errors;
  int pending;
  int cycles;
  int idle_pct;
  int stall_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  logic [31:0] slot_times [MAX_KEYFRAMES];
  int loaded;   // slots 0..loaded-1 hold keyframes

  catmull_rom_path_player dut (.*);

  path_player_checker chk (.*);

  always #5 clk = ~clk;

  // cycle limit guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side: random stall, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // one request on the input channel; returns at the edge that takes it
  task automatic send_req(input logic o, input logic [5:0] slot, input logic [31:0] t,
                          input logic [31:0] delta, input bit rand_pose);
    int gap;
    gap = 0;
    if (idle_pct > 0)
      while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    key_slot   <= slot;
    key_time   <= t;
    time_delta <= delta;
    if (rand_pose) begin
      key_pos_x <= $urandom;
      key_pos_y <= $urandom;
      key_pos_z <= $urandom;
      key_at_x  <= $urandom;
      key_at_y  <= $urandom;
      key_at_z  <= $urandom;
    end
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  // block idle, then write keyframe_count
  task automatic set_count(input logic [6:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // load slots 0..eff-1 in time order, then a run of ticks mixed with keyframe reloads
  task automatic run_phase(input logic [6:0] cnt, input logic [31:0] base,
                           input int step, input int ticks, input int idle,
                           input int stall, input bit hold);
    int eff, pick;
    logic [31:0] t, delta;
    idle_pct  = idle;
    stall_pct = stall;
    set_count(cnt);
    eff = cnt < MIN_KEYS ? MIN_KEYS : (cnt > MAX_KEYFRAMES ? MAX_KEYFRAMES : cnt);
    t = base;
    for (int s = 0; s < eff; s++) begin
      // some equal neighbouring times
      if (s > 0) t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(step, 1));
      slot_times[s] = t;
      send_req(OP_LOAD, 6'(s), t, $urandom, 1'b1);
    end
    if (eff > loaded) loaded = eff;
    for (int i = 0; i < ticks; i++) begin
      if (hold && i == 40) hold_reqs++;
      pick = $urandom_range(99);
      if (pick < 5) begin
        // reload a keyframe already in the table, same time, new pose
        int s;
        s = $urandom_range(loaded - 1);
        send_req(OP_LOAD, 6'(s), slot_times[s], $urandom, 1'b1);
      end else begin
        if (pick < 12) delta = '0;
        else if (pick < 15) delta = $urandom;
        else if (pick < 17) delta = 32'hFFFF_FFFF;
        else delta = $urandom_range(step, 0);
        send_req(OP_TICK, $urandom, $urandom, delta, 1'b0);
      end
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_LOAD;
    key_slot   = '0;
    key_time   = '0;
    key_pos_x  = '0;
    key_pos_y  = '0;
    key_pos_z  = '0;
    key_at_x   = '0;
    key_at_y   = '0;
    key_at_z   = '0;
    time_delta = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 7'd4;
    cycles     = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_reqs  = 0;
    hold_seen  = 0;
    hold_left  = 0;
    loaded     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: four keys, extreme poses, equal middle times
    set_count(7'd4);
    key_pos_x <= 32'h8000_0000;
    key_pos_y <= 32'h7FFF_FFFF;
    key_pos_z <= 32'h8000_0000;
    key_at_x  <= 32'h7FFF_FFFF;
    key_at_y  <= 32'h8000_0000;
    key_at_z  <= 32'h7FFF_FFFF;
    send_req(OP_LOAD, 6'd0, 32'h0000_0000, '0, 1'b0);
    key_pos_x <= 32'h7FFF_FFFF;
    key_pos_y <= 32'h8000_0000;
    key_pos_z <= 32'h7FFF_FFFF;
    key_at_x  <= 32'h8000_0000;
    key_at_y  <= 32'h7FFF_FFFF;
    key_at_z  <= 32'h8000_0000;
    send_req(OP_LOAD, 6'd1, 32'h0001_0000, '0, 1'b0);
    send_req(OP_LOAD, 6'd2, 32'h0001_0000, '0, 1'b1);
    send_req(OP_LOAD, 6'd3, 32'h0003_0000, '0, 1'b1);
    slot_times[0] = 32'h0;
    slot_times[1] = 32'h0001_0000;
    slot_times[2] = 32'h0001_0000;
    slot_times[3] = 32'h0003_0000;
    loaded = 4;
    send_req(OP_TICK, '0, '0, 32'h0000_0000, 1'b0);   // equal segment times: ratio saturates
    send_req(OP_TICK, '0, '0, 32'h0000_0001, 1'b0);   // before segment start
    send_req(OP_TICK, '0, '0, 32'h0000_FFFF, 1'b0);   // equal times, numerator zero
    send_req(OP_TICK, '0, '0, 32'h0000_0001, 1'b0);   // past the end: rewind
    send_req(OP_TICK, '0, '0, 32'hFFFF_FFFF, 1'b0);   // play time reaches the top of the range
    send_req(OP_TICK, '0, '0, 32'h0000_8000, 1'b0);

    // random phases: counts at the top end and beyond both ends, several idling mixes
    run_phase(7'd64,  32'h0,         32'h30000, 220, 0,  0,  1'b1);
    run_phase(7'd127, 32'h0,         32'h20000, 120, 48, 0,  1'b0);
    run_phase(7'd0,   32'hFFF0_0000, 32'h1000,  60,  0,  48, 1'b0);
    run_phase(7'd10,  32'h0,         32'h8000,  120, 7,  7,  1'b0);
    run_phase(7'd33,  32'h0,         32'h40000, 150, 48, 0,  1'b0);
    run_phase(7'd5,   32'h0,         32'h10000, 80,  0,  48, 1'b1);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
